### design/tdit_pkg.sv
`default_nettype none

package tdit_pkg;

  // default table depth
  localparam int unsigned MaxTilesDef = 256;

  // fixed field widths
  localparam int unsigned TileW  = 64;
  localparam int unsigned IndexW = 8;
  localparam int unsigned SlotW  = 8;
  localparam int unsigned CountW = 9;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgIndexBase = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBlankMode = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBlankIdx  = 2'd2;

  // control sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_OUTPUT
  } state_e;

  // search token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [SlotW-1:0] slot;
  } probe_t;

endpackage

`default_nettype wire

### design/tdit_cell.sv
`default_nettype none

module tdit_cell
  import tdit_pkg::*;
#(
  parameter int unsigned CELL_IDX = 0
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [2*TileW-1:0]  tile_i,
  input  wire logic [CountW-1:0]   count_i,
  input  wire probe_t              probe_i,
  output      probe_t              probe_o
);

  localparam logic [CountW-1:0] CellPos = CountW'(CELL_IDX);

  logic [2*TileW-1:0] entry_q;
  probe_t             probe_d, probe_q;
  logic               live, hit, wr_en;

  // this cell is searched only while the token is still looking
  assign live  = probe_i.valid && !probe_i.found;
  assign hit   = live && (CellPos < count_i) && (entry_q == tile_i);
  assign wr_en = live && (CellPos == count_i);

  always_comb begin
    probe_d = probe_i;
    if (hit) begin
      probe_d.found = 1'b1;
      probe_d.slot  = CellPos[SlotW-1:0];
    end
  end

  // stored tile: written when a missing tile reaches the first free slot
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q <= tile_i;
    end
  end

  // token register towards the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  assign probe_o = probe_q;

endmodule

`default_nettype wire

### design/tile_dedup_index_table_core.sv
// Flow: an accepted word is registered and a search token walks the cell row
// through each cell's token register before the result word is registered; a
// blank tile in blank mode skips the search. One tile at a time: a new word is
// taken only once the result word of the previous one has been taken.
// Reset: clears the tile count, the configuration and the sequencer; stored
// tiles are not cleared and are never read beyond the count.
`default_nettype none

module tile_dedup_index_table_core
  import tdit_pkg::*;
#(
  parameter int unsigned MAX_TILES = MaxTilesDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i,
  // input words
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  input  wire logic [2*TileW-1:0]   s_axis_tdata,  // tile_lo, tile_hi
  input  wire logic                 s_axis_tuser,  // new_image
  // result words
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output      logic [23:0]          m_axis_tdata   // name_index, is_new, is_blank,
                                                   // overflow, unique_total, zero pad
);

  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_TILES);

  state_e              state_q, state_d;
  logic [IndexW-1:0]   index_base_q, blank_index_q;
  logic                blank_mode_q;
  logic [CountW-1:0]   count_q, count_d;
  logic [2*TileW-1:0]  tile_q;
  logic                launch_q, launch_d;
  logic [IndexW-1:0]   name_q, name_d;
  logic                new_q, new_d, blank_q, blank_d, ovf_q, ovf_d;
  logic                in_acc, is_zero, take_blank;
  probe_t              chain [MAX_TILES+1];
  probe_t              last;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_base_q  <= '0;
      blank_mode_q  <= 1'b0;
      blank_index_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIndexBase: index_base_q  <= cfg_data_i[IndexW-1:0];
        CfgBlankMode: blank_mode_q  <= cfg_data_i[0];
        CfgBlankIdx:  blank_index_q <= cfg_data_i[IndexW-1:0];
        default: ;
      endcase
    end
  end

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign is_zero    = (s_axis_tdata == '0);
  assign take_blank = blank_mode_q && is_zero;

  // row of compare cells; token enters at cell 0 in the cycle after accept
  assign chain[0] = '{valid: launch_q, found: 1'b0, slot: '0};

  for (genvar k = 0; k < MAX_TILES; k++) begin : g_cell
    tdit_cell #(
      .CELL_IDX (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tile_i  (tile_q),
      .count_i (count_q),
      .probe_i (chain[k]),
      .probe_o (chain[k+1])
    );
  end

  assign last = chain[MAX_TILES];

  // sequencer: next state, count and result
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    launch_d      = 1'b0;
    name_d        = name_q;
    new_d         = new_q;
    blank_d       = blank_q;
    ovf_d         = ovf_q;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (s_axis_tuser) begin
            count_d = '0;
          end
          if (take_blank) begin
            name_d  = blank_index_q;
            new_d   = 1'b0;
            blank_d = 1'b1;
            ovf_d   = 1'b0;
            state_d = ST_OUTPUT;
          end else begin
            launch_d = 1'b1;
            state_d  = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (last.valid) begin
          blank_d = 1'b0;
          state_d = ST_OUTPUT;
          if (last.found) begin
            name_d = last.slot + index_base_q;
            new_d  = 1'b0;
            ovf_d  = 1'b0;
          end else begin
            // the tile takes (or would take) the first free slot
            name_d = count_q[IndexW-1:0] + index_base_q;
            if (count_q < MaxCount) begin
              new_d   = 1'b1;
              ovf_d   = 1'b0;
              count_d = count_q + CountW'(1);
            end else begin
              new_d = 1'b0;
              ovf_d = 1'b1;
            end
          end
        end
      end
      ST_OUTPUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      launch_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      launch_q <= launch_d;
    end
  end

  // tile held for the whole search; result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tile_q <= s_axis_tdata;
    end
    name_q  <= name_d;
    new_q   <= new_d;
    blank_q <= blank_d;
    ovf_q   <= ovf_d;
  end

  assign m_axis_tdata = {4'd0, count_q, ovf_q, blank_q, new_q, name_q};

endmodule

`default_nettype wire
